@@ design/biiw_pkg.sv @@
// Shared widths, types and constants for the box inverse inertia pipeline.
// No dependencies; every other design file refers to it by scoped names.
package biiw_pkg;

  localparam int FIELD_W       = 24;  // mass and half extent fields
  localparam int QUAT_W        = 16;  // Q1.14 quaternion parts
  localparam int SQ_W          = 48;  // square of a half extent
  localparam int DEN_W         = 49;  // sum of two squares
  localparam int NUM_W         = 26;  // three times the inverse mass
  localparam int QUOT_W        = 31;  // diagonal entry width
  localparam int DIV_MIN_W     = 80;  // divisor shifted by the quotient width
  localparam int QP_W          = 32;  // quaternion product
  localparam int RRAW_W        = 36;  // rotation entry before clamping
  localparam int R_W           = 31;  // clamped rotation entry, 28 fraction bits
  localparam int RFRAC         = 28;
  localparam int RPROD_W       = 62;  // product of two rotation entries
  localparam int P_W           = 32;  // rounded rotation product
  localparam int DPROD_W       = 64;  // diagonal times rotation product
  localparam int SUM_W         = 66;  // sum of three such products
  localparam int WORLD_W       = 32;
  localparam int N_ENTRY       = 6;   // unique world tensor entries
  localparam int N_TERM        = 18;  // entries times three axes
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [QUOT_W-1:0] DIAG_MAX = {QUOT_W{1'b1}};

  // Row and column of each unique world entry: xx, xy, xz, yy, yz, zz
  localparam int ENTRY_I [N_ENTRY] = '{0, 0, 0, 1, 1, 2};
  localparam int ENTRY_J [N_ENTRY] = '{0, 1, 2, 1, 2, 2};

  typedef logic [QUOT_W-1:0]        diag_t;
  typedef logic signed [P_W-1:0]    pterm_t;
  typedef logic signed [WORLD_W-1:0] world_t;

  typedef struct packed {
    logic signed [QUAT_W-1:0] w;
    logic signed [QUAT_W-1:0] x;
    logic signed [QUAT_W-1:0] y;
    logic signed [QUAT_W-1:0] z;
  } quat_t;

endpackage

@@ design/biiw_div.sv @@
// Pipelined restoring divider: min(num * 2^(2F) / den, 2^31-1), zero for den zero.
// One quotient bit per stage, 32 register stages. Uses biiw_pkg.
module biiw_div #(
  parameter int FRAC_BITS = biiw_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [biiw_pkg::NUM_W-1:0]   num_i,
  input  logic [biiw_pkg::DEN_W-1:0]   den_i,
  output biiw_pkg::diag_t              quot_o
);

  localparam int SNUM_W = biiw_pkg::NUM_W + 2 * FRAC_BITS;
  localparam int REM_W  = (SNUM_W > biiw_pkg::DIV_MIN_W) ? SNUM_W : biiw_pkg::DIV_MIN_W;
  localparam int QW     = biiw_pkg::QUOT_W;

  logic [REM_W-1:0]            rem_q  [QW+1];
  logic [biiw_pkg::DEN_W-1:0]  den_q  [QW+1];
  logic [QW-1:0]               quo_q  [QW+1];
  logic                        sat_q  [QW+1];
  logic                        zero_q [QW+1];

  logic [REM_W-1:0] num_ext;
  logic [REM_W-1:0] den_top;

  // Scale the dividend and flag overflow before the bit loop
  assign num_ext = REM_W'(num_i) << (2 * FRAC_BITS);
  assign den_top = REM_W'(den_i) << QW;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_ext;
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      sat_q[0]  <= (num_ext >= den_top);
      zero_q[0] <= (den_i == '0);
    end
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [REM_W-1:0] trial;
    assign trial = REM_W'(den_q[k-1]) << B;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k]  <= den_q[k-1];
        sat_q[k]  <= sat_q[k-1];
        zero_q[k] <= zero_q[k-1];
        if (rem_q[k-1] >= trial) begin
          rem_q[k] <= rem_q[k-1] - trial;
          quo_q[k] <= quo_q[k-1] | (QW'(1) << B);
        end else begin
          rem_q[k] <= rem_q[k-1];
          quo_q[k] <= quo_q[k-1];
        end
      end
    end
  end

  // Select zero, saturated or exact quotient
  always_comb begin
    if (zero_q[QW])     quot_o = '0;
    else if (sat_q[QW]) quot_o = biiw_pkg::DIAG_MAX;
    else                quot_o = quo_q[QW];
  end

endmodule

@@ design/biiw_rot.sv @@
// Rotation matrix from a quaternion and the rounded products R_ik*R_jk.
// Four register stages. Uses biiw_pkg.
module biiw_rot (
  input  logic              clk_i,
  input  logic              en_i,
  input  biiw_pkg::quat_t   quat_i,
  output biiw_pkg::pterm_t  p_o [biiw_pkg::N_TERM]
);

  localparam logic signed [biiw_pkg::RRAW_W-1:0] ONE   = biiw_pkg::RRAW_W'(1) <<< biiw_pkg::RFRAC;
  localparam logic signed [biiw_pkg::RRAW_W-1:0] RLIM  = biiw_pkg::RRAW_W'(1) <<< (biiw_pkg::RFRAC + 1);
  localparam logic signed [biiw_pkg::RPROD_W:0]  RHALF = (biiw_pkg::RPROD_W + 1)'(1) <<< (biiw_pkg::RFRAC - 1);

  logic signed [biiw_pkg::QP_W-1:0]    xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [biiw_pkg::RRAW_W-1:0]  raw   [3][3];
  logic signed [biiw_pkg::R_W-1:0]     r_q   [3][3];
  logic signed [biiw_pkg::RPROD_W-1:0] prd_q [biiw_pkg::N_TERM];
  biiw_pkg::pterm_t                    p_q   [biiw_pkg::N_TERM];

  function automatic logic signed [biiw_pkg::RRAW_W-1:0] ext(
      input logic signed [biiw_pkg::QP_W-1:0] v);
    ext = biiw_pkg::RRAW_W'(v);
  endfunction

  // Quaternion component products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= quat_i.x * quat_i.x;
      yy_q <= quat_i.y * quat_i.y;
      zz_q <= quat_i.z * quat_i.z;
      xy_q <= quat_i.x * quat_i.y;
      xz_q <= quat_i.x * quat_i.z;
      yz_q <= quat_i.y * quat_i.z;
      wx_q <= quat_i.w * quat_i.x;
      wy_q <= quat_i.w * quat_i.y;
      wz_q <= quat_i.w * quat_i.z;
    end
  end

  // Form the matrix entries with 28 fraction bits
  always_comb begin
    raw[0][0] = ONE - 2 * (ext(yy_q) + ext(zz_q));
    raw[0][1] = 2 * (ext(xy_q) - ext(wz_q));
    raw[0][2] = 2 * (ext(xz_q) + ext(wy_q));
    raw[1][0] = 2 * (ext(xy_q) + ext(wz_q));
    raw[1][1] = ONE - 2 * (ext(xx_q) + ext(zz_q));
    raw[1][2] = 2 * (ext(yz_q) - ext(wx_q));
    raw[2][0] = 2 * (ext(xz_q) - ext(wy_q));
    raw[2][1] = 2 * (ext(yz_q) + ext(wx_q));
    raw[2][2] = ONE - 2 * (ext(xx_q) + ext(yy_q));
  end

  // Clamp each entry to [-2.0, 2.0]
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (raw[i][j] > RLIM)       r_q[i][j] <= biiw_pkg::R_W'(RLIM);
          else if (raw[i][j] < -RLIM) r_q[i][j] <= biiw_pkg::R_W'(-RLIM);
          else                        r_q[i][j] <= biiw_pkg::R_W'(raw[i][j]);
        end
      end
    end
  end

  // Multiply entry pairs, then round half up to 28 fraction bits
  for (genvar e = 0; e < biiw_pkg::N_ENTRY; e++) begin : g_ent
    for (genvar k = 0; k < 3; k++) begin : g_ax
      localparam int EI = biiw_pkg::ENTRY_I[e];
      localparam int EJ = biiw_pkg::ENTRY_J[e];
      localparam int T  = e * 3 + k;
      logic signed [biiw_pkg::RPROD_W:0] rnd;
      assign rnd = (biiw_pkg::RPROD_W + 1)'(prd_q[T]) + RHALF;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prd_q[T] <= r_q[EI][k] * r_q[EJ][k];
          p_q[T]   <= biiw_pkg::P_W'(rnd >>> biiw_pkg::RFRAC);
        end
      end
      assign p_o[T] = p_q[T];
    end
  end

endmodule

@@ design/biiw_world.sv @@
// World tensor entries: sum over axes of D_k * p, rounded and saturated.
// Two register stages; the second is the output register. Uses biiw_pkg.
module biiw_world (
  input  logic              clk_i,
  input  logic              en_i,
  input  biiw_pkg::diag_t   d_i     [3],
  input  biiw_pkg::pterm_t  p_i     [biiw_pkg::N_TERM],
  output biiw_pkg::world_t  world_o [biiw_pkg::N_ENTRY]
);

  localparam logic signed [biiw_pkg::SUM_W-1:0] SHALF = biiw_pkg::SUM_W'(1) <<< (biiw_pkg::RFRAC - 1);
  localparam int RES_W = biiw_pkg::SUM_W - biiw_pkg::RFRAC;
  localparam logic signed [RES_W-1:0] WMAX = RES_W'({1'b0, {(biiw_pkg::WORLD_W-1){1'b1}}});
  localparam logic signed [RES_W-1:0] WMIN = -WMAX - RES_W'(1);

  logic signed [biiw_pkg::DPROD_W-1:0] dp_q [biiw_pkg::N_TERM];
  biiw_pkg::world_t                    w_q  [biiw_pkg::N_ENTRY];

  // Scale each rounded rotation product by its diagonal entry
  for (genvar t = 0; t < biiw_pkg::N_TERM; t++) begin : g_term
    logic signed [biiw_pkg::P_W-1:0] d_s;
    assign d_s = biiw_pkg::P_W'({1'b0, d_i[t % 3]});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dp_q[t] <= d_s * p_i[t];
      end
    end
  end

  // Sum three terms, round half up, saturate to 32 bits
  for (genvar e = 0; e < biiw_pkg::N_ENTRY; e++) begin : g_ent
    logic signed [biiw_pkg::SUM_W-1:0] sum;
    logic signed [RES_W-1:0]           res;
    assign sum = biiw_pkg::SUM_W'(dp_q[e*3]) + biiw_pkg::SUM_W'(dp_q[e*3+1])
               + biiw_pkg::SUM_W'(dp_q[e*3+2]) + SHALF;
    assign res = RES_W'(sum >>> biiw_pkg::RFRAC);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (res > WMAX)      w_q[e] <= biiw_pkg::WORLD_W'(WMAX);
        else if (res < WMIN) w_q[e] <= biiw_pkg::WORLD_W'(WMIN);
        else                 w_q[e] <= biiw_pkg::WORLD_W'(res);
      end
    end
    assign world_o[e] = w_q[e];
  end

endmodule

@@ design/box_inverse_inertia_world.sv @@
// Box inverse inertia, body frame and rotated world frame, as a 37-stage pipeline.
// Instantiates biiw_div, biiw_rot and biiw_world; uses biiw_pkg.
//
// Usage: one body per transfer on the input channel (inverse mass, half
// extents, quaternion), one result per transfer on the output channel (three
// body-frame diagonal entries, six world tensor entries). A transfer happens
// when valid is high and stall is low.
// Each body passes through 37 register stages. The pipeline takes one body
// per cycle while in_stall_o is low; the three diagonal entries come from
// bit-per-stage dividers that run in parallel, with the rotation path delayed
// to meet them. The static mass limit register is written through cfg_we_i;
// the user must write it only while the pipeline is empty, as the block
// itself does not enforce this. An inverse mass at or below the limit gives
// an all-zero result.
// Reset clears all valid bits and the limit register; data registers are not
// reset. When the receiver stalls, the whole pipeline holds and in_stall_o
// rises, so nothing is dropped; bubbles still advance while the output
// register is empty.
module box_inverse_inertia_world #(
  parameter int FRAC_BITS = biiw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [biiw_pkg::FIELD_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [biiw_pkg::FIELD_W-1:0]  inverse_mass_i,
  input  logic [biiw_pkg::FIELD_W-1:0]  half_x_i,
  input  logic [biiw_pkg::FIELD_W-1:0]  half_y_i,
  input  logic [biiw_pkg::FIELD_W-1:0]  half_z_i,
  input  logic signed [biiw_pkg::QUAT_W-1:0] quat_w_i,
  input  logic signed [biiw_pkg::QUAT_W-1:0] quat_x_i,
  input  logic signed [biiw_pkg::QUAT_W-1:0] quat_y_i,
  input  logic signed [biiw_pkg::QUAT_W-1:0] quat_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [biiw_pkg::QUOT_W-1:0]   body_inv_xx_o,
  output logic [biiw_pkg::QUOT_W-1:0]   body_inv_yy_o,
  output logic [biiw_pkg::QUOT_W-1:0]   body_inv_zz_o,
  output logic signed [biiw_pkg::WORLD_W-1:0] world_xx_o,
  output logic signed [biiw_pkg::WORLD_W-1:0] world_xy_o,
  output logic signed [biiw_pkg::WORLD_W-1:0] world_xz_o,
  output logic signed [biiw_pkg::WORLD_W-1:0] world_yy_o,
  output logic signed [biiw_pkg::WORLD_W-1:0] world_yz_o,
  output logic signed [biiw_pkg::WORLD_W-1:0] world_zz_o
);

  localparam int LAT   = 37;  // total register stages
  localparam int QDLY  = 31;  // stage at which the quaternion enters the rotation path

  logic                          en;
  logic [biiw_pkg::FIELD_W-1:0]  limit_q;
  logic                          vld_q  [1:LAT];
  logic                          stat_q [1:LAT];
  biiw_pkg::quat_t               qd_q   [1:QDLY];
  logic [biiw_pkg::FIELD_W-1:0]  im_q, hx_q, hy_q, hz_q;
  logic [biiw_pkg::SQ_W-1:0]     sqx_q, sqy_q, sqz_q;
  logic [biiw_pkg::NUM_W-1:0]    num2_q, num3_q;
  logic [biiw_pkg::DEN_W-1:0]    den_q  [3];
  biiw_pkg::diag_t               d_div  [3];
  biiw_pkg::diag_t               d1_q   [3];
  biiw_pkg::diag_t               d2_q   [3];
  biiw_pkg::pterm_t              p_term [biiw_pkg::N_TERM];
  biiw_pkg::world_t              world  [biiw_pkg::N_ENTRY];
  biiw_pkg::quat_t               quat_in;

  // Advance whenever the output register is free or being taken
  assign en         = !vld_q[LAT] || !out_stall_i;
  assign in_stall_o = !en;
  assign quat_in    = '{w: quat_w_i, x: quat_x_i, y: quat_y_i, z: quat_z_i};

  // Hold the static mass limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= LAT; s++) vld_q[s] <= 1'b0;
    end else if (en) begin
      vld_q[1] <= in_valid_i;
      for (int s = 2; s <= LAT; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  // Capture inputs, then squares, then denominators; delay flags, quaternion and diagonals
  always_ff @(posedge clk_i) begin
    if (en) begin
      im_q      <= inverse_mass_i;
      hx_q      <= half_x_i;
      hy_q      <= half_y_i;
      hz_q      <= half_z_i;
      stat_q[1] <= (inverse_mass_i <= limit_q);
      qd_q[1]   <= quat_in;
      for (int s = 2; s <= LAT; s++)  stat_q[s] <= stat_q[s-1];
      for (int s = 2; s <= QDLY; s++) qd_q[s]   <= qd_q[s-1];

      sqx_q  <= hx_q * hx_q;
      sqy_q  <= hy_q * hy_q;
      sqz_q  <= hz_q * hz_q;
      num2_q <= biiw_pkg::NUM_W'(im_q) * biiw_pkg::NUM_W'(3);

      den_q[0] <= biiw_pkg::DEN_W'(sqy_q) + biiw_pkg::DEN_W'(sqz_q);
      den_q[1] <= biiw_pkg::DEN_W'(sqx_q) + biiw_pkg::DEN_W'(sqz_q);
      den_q[2] <= biiw_pkg::DEN_W'(sqx_q) + biiw_pkg::DEN_W'(sqy_q);
      num3_q   <= num2_q;

      for (int a = 0; a < 3; a++) begin
        d1_q[a] <= d_div[a];
        d2_q[a] <= d1_q[a];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_div
    biiw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (num3_q),
      .den_i  (den_q[a]),
      .quot_o (d_div[a])
    );
  end

  biiw_rot u_rot (
    .clk_i  (clk_i),
    .en_i   (en),
    .quat_i (qd_q[QDLY]),
    .p_o    (p_term)
  );

  biiw_world u_world (
    .clk_i   (clk_i),
    .en_i    (en),
    .d_i     (d_div),
    .p_i     (p_term),
    .world_o (world)
  );

  // Drive results, zeroed for a static body
  assign out_valid_o   = vld_q[LAT];
  assign body_inv_xx_o = stat_q[LAT] ? '0 : d2_q[0];
  assign body_inv_yy_o = stat_q[LAT] ? '0 : d2_q[1];
  assign body_inv_zz_o = stat_q[LAT] ? '0 : d2_q[2];
  assign world_xx_o    = stat_q[LAT] ? '0 : world[0];
  assign world_xy_o    = stat_q[LAT] ? '0 : world[1];
  assign world_xz_o    = stat_q[LAT] ? '0 : world[2];
  assign world_yy_o    = stat_q[LAT] ? '0 : world[3];
  assign world_yz_o    = stat_q[LAT] ? '0 : world[4];
  assign world_zz_o    = stat_q[LAT] ? '0 : world[5];

  // Diagonal world entries are sums of nonnegative terms
  a_diag_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!world_xx_o[31] && !world_yy_o[31] && !world_zz_o[31]))
    else $error("negative diagonal world entry");

  // A stalled result stays presented
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(world_xy_o)
                                   && $stable(body_inv_xx_o))
    else $error("stalled result lost or changed");

  // Input stalls only while the output is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

endmodule
